// ----- design/hzf_pkg.sv -----
// ----------------------------------------------------------------------------
// hzf_pkg
// Shared types, field positions and forward codes of the hazard and
// forwarding unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hzf_pkg;

  // Width of the value fields on the channels, and width of the datapath
  // that the values are masked to.
  localparam int VALUE_WIDTH = 64;
  localparam int DATA_WIDTH  = 64;
  localparam logic [VALUE_WIDTH-1:0] DATA_MASK =
    {VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - DATA_WIDTH);

  localparam int REG_IDX_WIDTH = 5;
  localparam int NUM_SRC       = 3;

  // Decode flag bits
  localparam int ID_NOP     = 0;
  localparam int ID_USE1    = 1;
  localparam int ID_FP1     = 2;
  localparam int ID_USE2    = 3;
  localparam int ID_FP2     = 4;
  localparam int ID_USE3    = 5;

  // Execute / memory flag bits
  localparam int ST_NOP     = 0;
  localparam int ST_WR      = 1;
  localparam int ST_WR_FP   = 2;
  localparam int ST_LOAD    = 3;  // execute: is load; memory: result from memory
  localparam int ST_CSR     = 4;

  typedef enum logic [1:0] {
    FWD_RF  = 2'd0,
    FWD_EX  = 2'd1,
    FWD_MEM = 2'd2
  } hzf_fwd_e;

  typedef struct packed {
    logic [5:0]             id_flags;
    logic [14:0]            id_sources;
    logic [VALUE_WIDTH-1:0] src1_value;
    logic [VALUE_WIDTH-1:0] src2_value;
    logic [VALUE_WIDTH-1:0] src3_value;
    logic [4:0]             ex_flags;
    logic [4:0]             ex_dest;
    logic [VALUE_WIDTH-1:0] ex_alu_result;
    logic [4:0]             mem_flags;
    logic [4:0]             mem_dest;
    logic [VALUE_WIDTH-1:0] mem_alu_result;
    logic [VALUE_WIDTH-1:0] mem_load_data;
  } hzf_in_t;

  typedef struct packed {
    logic                   stall_res;
    logic [VALUE_WIDTH-1:0] op1_value;
    logic [VALUE_WIDTH-1:0] op2_value;
    logic [VALUE_WIDTH-1:0] op3_value;
    logic [5:0]             forward_select;
  } hzf_out_t;

endpackage

`default_nettype wire

// ----- design/hzf_if.sv -----
// ----------------------------------------------------------------------------
// hzf_if
// Valid/ready channel interfaces for snapshots, results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface hzf_in_if
  import hzf_pkg::*;
;
  logic    valid;
  logic    ready;
  hzf_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface hzf_out_if
  import hzf_pkg::*;
;
  logic     valid;
  logic     ready;
  hzf_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface hzf_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/hzf_decide.sv -----
// ----------------------------------------------------------------------------
// hzf_decide
// Hazard detection and operand forwarding for one registered snapshot.
// ----------------------------------------------------------------------------
`default_nettype none

module hzf_decide
  import hzf_pkg::*;
(
  input  hzf_in_t  item_i,
  input  logic     fwd_en_i,
  output hzf_out_t res_o
);

  logic                     ex_wr, mem_wr;
  logic [VALUE_WIDTH-1:0]   ex_val, mem_val;
  logic [NUM_SRC-1:0]       uses, is_fp, ex_match, mem_match;
  logic [REG_IDX_WIDTH-1:0] idx [NUM_SRC];
  logic [VALUE_WIDTH-1:0]   raw [NUM_SRC];
  logic [VALUE_WIDTH-1:0]   val [NUM_SRC];
  logic [5:0]               sel;
  logic                     stall, fwd_ok;

  assign ex_wr  = !item_i.ex_flags[ST_NOP] && item_i.ex_flags[ST_WR];
  assign mem_wr = !item_i.mem_flags[ST_NOP] && item_i.mem_flags[ST_WR];
  assign ex_val = item_i.ex_alu_result & DATA_MASK;
  assign mem_val = (item_i.mem_flags[ST_LOAD] ? item_i.mem_load_data
                                               : item_i.mem_alu_result) & DATA_MASK;

  assign uses  = {item_i.id_flags[ID_USE3], item_i.id_flags[ID_USE2],
                  item_i.id_flags[ID_USE1]};
  assign is_fp = {1'b1, item_i.id_flags[ID_FP2], item_i.id_flags[ID_FP1]};
  assign idx[0] = item_i.id_sources[4:0];
  assign idx[1] = item_i.id_sources[9:5];
  assign idx[2] = item_i.id_sources[14:10];
  assign raw[0] = item_i.src1_value & DATA_MASK;
  assign raw[1] = item_i.src2_value & DATA_MASK;
  assign raw[2] = item_i.src3_value & DATA_MASK;

  // Integer x0 is hard-wired to zero and never matches.
  always_comb begin
    for (int i = 0; i < NUM_SRC; i++) begin
      ex_match[i]  = uses[i] && ex_wr && (idx[i] == item_i.ex_dest) &&
                     (is_fp[i] == item_i.ex_flags[ST_WR_FP]) &&
                     (is_fp[i] || (idx[i] != '0));
      mem_match[i] = uses[i] && mem_wr && (idx[i] == item_i.mem_dest) &&
                     (is_fp[i] == item_i.mem_flags[ST_WR_FP]) &&
                     (is_fp[i] || (idx[i] != '0));
    end
  end

  always_comb begin
    stall  = 1'b0;
    fwd_ok = 1'b0;
    if (item_i.ex_flags[ST_CSR] || item_i.mem_flags[ST_CSR]) begin
      stall = 1'b1;
    end else if (item_i.id_flags[ID_NOP]) begin
      stall = 1'b0;
    end else if (!fwd_en_i) begin
      stall = (|ex_match) || (|mem_match);
    end else if ((|ex_match) && item_i.ex_flags[ST_LOAD]) begin
      stall = 1'b1;
    end else begin
      fwd_ok = 1'b1;
    end
  end

  // Execute has priority over memory.
  always_comb begin
    sel = '0;
    for (int i = 0; i < NUM_SRC; i++) begin
      val[i] = raw[i];
      if (fwd_ok && ex_match[i]) begin
        val[i] = ex_val;
        sel[2*i +: 2] = FWD_EX;
      end else if (fwd_ok && mem_match[i]) begin
        val[i] = mem_val;
        sel[2*i +: 2] = FWD_MEM;
      end
    end
  end

  assign res_o.stall_res      = stall;
  assign res_o.op1_value      = val[0];
  assign res_o.op2_value      = val[1];
  assign res_o.op3_value      = val[2];
  assign res_o.forward_select = sel;

endmodule

`default_nettype wire

// ----- design/pipeline_hazard_forwarding_unit_core.sv -----
// ----------------------------------------------------------------------------
// pipeline_hazard_forwarding_unit_core
// Stall decision and operand forwarding for a five-stage pipeline.
// ----------------------------------------------------------------------------
// Stages: two register stages (snapshot register, result register); each
//   result is registered from its snapshot through the decision logic.
// Throughput: one transaction per cycle; a new snapshot is taken every cycle
//   while the result side keeps taking results.
// Reset: both stage valid flags clear; forwarding comes up enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module pipeline_hazard_forwarding_unit_core
  import hzf_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hzf_cfg_if.sink    cfg_i,
  hzf_in_if.sink     in_i,
  hzf_out_if.source  out_o
);

  // One config bit, always ready; user writes only while idle (unenforced).
  logic fwd_en_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_en_q <= 1'b1;
    end else if (cfg_i.valid) begin
      fwd_en_q <= cfg_i.data;
    end
  end

  // Stage handshake: the result register advances when empty or taken,
  // the snapshot register advances when empty or when it can move on.
  logic     snap_valid_q, res_valid_q;
  logic     res_adv, snap_adv;
  hzf_in_t  snap_q;
  hzf_out_t res_d, res_q;

  assign res_adv  = !res_valid_q || out_o.ready;
  assign snap_adv = !snap_valid_q || res_adv;
  assign in_i.ready = snap_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (snap_adv) begin
        snap_valid_q <= in_i.valid;
      end
      if (res_adv) begin
        res_valid_q <= snap_valid_q;
      end
    end
  end

  // Capture the snapshot on every accepted transaction.
  always_ff @(posedge clk_i) begin
    if (snap_adv && in_i.valid) begin
      snap_q <= in_i.payload;
    end
  end

  // Hazard check and forwarding mux sit between the two registers.
  hzf_decide u_decide (
    .item_i   (snap_q),
    .fwd_en_i (fwd_en_q),
    .res_o    (res_d)
  );

  // Hold the result while the consumer stalls, advance otherwise.
  always_ff @(posedge clk_i) begin
    if (res_adv && snap_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid   = res_valid_q;
  assign out_o.payload = res_q;

endmodule

`default_nettype wire

// ----- design/hzf_checker.sv -----
// ----------------------------------------------------------------------------
// hzf_checker
// Port-level assertions for the hazard and forwarding unit.
// ----------------------------------------------------------------------------
`default_nettype none

module hzf_checker
  import hzf_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_i,
  input wire logic     out_valid_i,
  input wire logic     out_ready_i,
  input wire hzf_out_t out_payload_i
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result dropped or changed while stalled");

  // Input only backs up when both stages are full and the output is stalled.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input blocked without output backpressure");

  // A stall never forwards anything.
  a_stall_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.stall_res |-> out_payload_i.forward_select == '0)
    else $error("forward select set on a stalled result");

  // No source selects an undefined forward code.
  a_sel_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_payload_i.forward_select[1:0] != 2'd3) &&
                    (out_payload_i.forward_select[3:2] != 2'd3) &&
                    (out_payload_i.forward_select[5:4] != 2'd3))
    else $error("invalid forward select code");

endmodule

bind pipeline_hazard_forwarding_unit_core hzf_checker u_hzf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);

`default_nettype wire

// ----- tb/sv/tb_pipeline_hazard_forwarding_unit_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pipeline_hazard_forwarding_unit_core
// Self-checking bench for the hazard and forwarding unit: drives pipeline
// snapshots and forwarding settings over the valid/ready channels, predicts
// stall and forwarded operands per snapshot, and compares each result.
// ----------------------------------------------------------------------------

module tb_pipeline_hazard_forwarding_unit_core;
  import hzf_pkg::*;

  // Bit masks of the decode and stage flag fields
  localparam logic [5:0] ID_NOP_M = 6'(1) << ID_NOP;
  localparam logic [5:0] USE1_M   = 6'(1) << ID_USE1;
  localparam logic [5:0] FP1_M    = 6'(1) << ID_FP1;
  localparam logic [5:0] USE2_M   = 6'(1) << ID_USE2;
  localparam logic [5:0] FP2_M    = 6'(1) << ID_FP2;
  localparam logic [5:0] USE3_M   = 6'(1) << ID_USE3;
  localparam logic [4:0] NOP_M    = 5'(1) << ST_NOP;
  localparam logic [4:0] WR_M     = 5'(1) << ST_WR;
  localparam logic [4:0] WRFP_M   = 5'(1) << ST_WR_FP;
  localparam logic [4:0] LOAD_M   = 5'(1) << ST_LOAD;
  localparam logic [4:0] CSR_M    = 5'(1) << ST_CSR;

  localparam int IDLE_PCT     = 12;
  localparam int HOLD_CYCLES  = 150;   // long result-side hold-off
  localparam int SETTLE_GAP   = 4;     // covers the two register stages
  localparam int STALL_LIMIT  = 1000;  // cycles without any transaction

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the result of each accepted snapshot and checks
  // results in order against those predictions.
  // --------------------------------------------------------------------------
  class hazard_scoreboard;
    hzf_out_t expected_q[$];
    logic     forwarding_on;
    int       mismatches;

    function new();
      forwarding_on = 1'b1;
      mismatches    = 0;
    endfunction

    function void set_forwarding(logic on);
      forwarding_on = on;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Integer register 0 is hard-wired, so it never matches a writer.
    function bit source_hits(bit uses, logic [REG_IDX_WIDTH-1:0] idx, bit is_fp,
                             bit wr, logic [REG_IDX_WIDTH-1:0] dest, bit wr_fp);
      return uses && wr && (idx == dest) && (is_fp == wr_fp) && (is_fp || idx != '0);
    endfunction

    function hzf_out_t predict_operands(hzf_in_t s);
      logic [VALUE_WIDTH-1:0]   val     [NUM_SRC];
      logic [REG_IDX_WIDTH-1:0] idx     [NUM_SRC];
      bit                       uses    [NUM_SRC];
      bit                       is_fp   [NUM_SRC];
      bit                       hit_ex  [NUM_SRC];
      bit                       hit_mem [NUM_SRC];
      bit                       ex_wr, mem_wr, any_ex, any_mem, stall;
      logic [VALUE_WIDTH-1:0]   mem_val;
      logic [5:0]               sel;
      hzf_out_t                 r;

      val    = '{s.src1_value & DATA_MASK, s.src2_value & DATA_MASK,
                 s.src3_value & DATA_MASK};
      idx    = '{s.id_sources[4:0], s.id_sources[9:5], s.id_sources[14:10]};
      uses   = '{s.id_flags[ID_USE1], s.id_flags[ID_USE2], s.id_flags[ID_USE3]};
      is_fp  = '{s.id_flags[ID_FP1], s.id_flags[ID_FP2], 1'b1};
      ex_wr  = !s.ex_flags[ST_NOP] && s.ex_flags[ST_WR];
      mem_wr = !s.mem_flags[ST_NOP] && s.mem_flags[ST_WR];
      mem_val = (s.mem_flags[ST_LOAD] ? s.mem_load_data : s.mem_alu_result) & DATA_MASK;
      any_ex  = 1'b0;
      any_mem = 1'b0;
      stall   = 1'b0;
      sel     = '0;

      for (int i = 0; i < NUM_SRC; i++) begin
        hit_ex[i]  = source_hits(uses[i], idx[i], is_fp[i], ex_wr, s.ex_dest,
                                 s.ex_flags[ST_WR_FP]);
        hit_mem[i] = source_hits(uses[i], idx[i], is_fp[i], mem_wr, s.mem_dest,
                                 s.mem_flags[ST_WR_FP]);
        any_ex  = any_ex || hit_ex[i];
        any_mem = any_mem || hit_mem[i];
      end

      if (s.ex_flags[ST_CSR] || s.mem_flags[ST_CSR]) begin
        stall = 1'b1;
      end else if (s.id_flags[ID_NOP]) begin
        stall = 1'b0;
      end else if (!forwarding_on) begin
        stall = any_ex || any_mem;
      end else if (any_ex && s.ex_flags[ST_LOAD]) begin
        stall = 1'b1;
      end else begin
        for (int i = 0; i < NUM_SRC; i++) begin
          if (hit_ex[i]) begin
            val[i]         = s.ex_alu_result & DATA_MASK;
            sel[2*i +: 2]  = FWD_EX;
          end else if (hit_mem[i]) begin
            val[i]         = mem_val;
            sel[2*i +: 2]  = FWD_MEM;
          end
        end
      end

      r.stall_res      = stall;
      r.op1_value      = val[0];
      r.op2_value      = val[1];
      r.op3_value      = val[2];
      r.forward_select = sel;
      return r;
    endfunction

    function void note_snapshot(hzf_in_t s);
      expected_q.insert(expected_q.size(), predict_operands(s));
    endfunction

    function void compare_field(string name, logic [VALUE_WIDTH-1:0] exp_v,
                                logic [VALUE_WIDTH-1:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %h, actual %h", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(hzf_out_t got);
      hzf_out_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result arrived with no snapshot outstanding");
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("stall_res", VALUE_WIDTH'(exp_r.stall_res), VALUE_WIDTH'(got.stall_res));
      compare_field("op1_value", exp_r.op1_value, got.op1_value);
      compare_field("op2_value", exp_r.op2_value, got.op2_value);
      compare_field("op3_value", exp_r.op3_value, got.op3_value);
      compare_field("forward_select", VALUE_WIDTH'(exp_r.forward_select),
                    VALUE_WIDTH'(got.forward_select));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   quiet;         // no idling on either side while set
  bit   hold_results;  // ask the result side for one long hold-off

  hazard_scoreboard sb = new();

  hzf_in_if  in_bus ();
  hzf_out_if out_bus ();
  hzf_cfg_if cfg_bus ();

  pipeline_hazard_forwarding_unit_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample every handshake at the rising edge. Inputs change only at
  // the falling edge, so these values are settled here.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.set_forwarding(cfg_bus.data);
      if (in_bus.valid && in_bus.ready) sb.note_snapshot(in_bus.payload);
      if (out_bus.valid && out_bus.ready) sb.check_result(out_bus.payload);
    end
  end

  // Watchdog: end the run once too many cycles pass without any transaction.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready) || !rst_ni) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_pipeline_hazard_forwarding_unit_core: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: drop ready at random, hold off for a long stretch when asked
  // so the unit fills up and pushes back on snapshots.
  // --------------------------------------------------------------------------
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_results) begin
        out_bus.ready = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk_i);
        hold_results = 1'b0;
      end
      out_bus.ready = quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Build a snapshot from flags and indices; register and stage values random.
  function automatic hzf_in_t shot(logic [5:0] idf, logic [4:0] s1, logic [4:0] s2,
                                   logic [4:0] s3, logic [4:0] exf, logic [4:0] exd,
                                   logic [4:0] mf, logic [4:0] md);
    hzf_in_t s;
    s.id_flags       = idf;
    s.id_sources     = {s3, s2, s1};
    s.src1_value     = VALUE_WIDTH'({$urandom, $urandom});
    s.src2_value     = VALUE_WIDTH'({$urandom, $urandom});
    s.src3_value     = VALUE_WIDTH'({$urandom, $urandom});
    s.ex_flags       = exf;
    s.ex_dest        = exd;
    s.ex_alu_result  = VALUE_WIDTH'({$urandom, $urandom});
    s.mem_flags      = mf;
    s.mem_dest       = md;
    s.mem_alu_result = VALUE_WIDTH'({$urandom, $urandom});
    s.mem_load_data  = VALUE_WIDTH'({$urandom, $urandom});
    return s;
  endfunction

  // Pick a source index that often hits one of the writers.
  function automatic logic [4:0] pick_index(logic [4:0] exd, logic [4:0] md);
    case ($urandom_range(0, 3))
      0:       return exd;
      1:       return md;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  // Random snapshot biased toward register matches; keep CSR ops and
  // nopped stages rare so most snapshots reach the forwarding paths.
  function automatic hzf_in_t random_snapshot();
    hzf_in_t    s;
    logic [4:0] exd;
    logic [4:0] md;
    exd = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(0, 31));
    md  = ($urandom_range(0, 2) == 0) ? exd : 5'($urandom_range(0, 31));
    s = shot(6'($urandom), pick_index(exd, md), pick_index(exd, md),
             pick_index(exd, md), 5'($urandom), exd, 5'($urandom), md);
    if ($urandom_range(0, 9) != 0) s.ex_flags[ST_CSR]  = 1'b0;
    if ($urandom_range(0, 9) != 0) s.mem_flags[ST_CSR] = 1'b0;
    if ($urandom_range(0, 7) != 0) s.id_flags[ID_NOP]  = 1'b0;
    if ($urandom_range(0, 3) != 0) s.ex_flags[ST_NOP]  = 1'b0;
    if ($urandom_range(0, 3) != 0) s.mem_flags[ST_NOP] = 1'b0;
    return s;
  endfunction

  // Offer one snapshot from the falling edge; return at the falling edge
  // after the transaction, with valid still high.
  task automatic send_snapshot(hzf_in_t s);
    in_bus.valid   = 1'b1;
    in_bus.payload = s;
    do @(posedge clk_i); while (!in_bus.ready);
    @(negedge clk_i);
  endtask

  // Write the forwarding enable; only called while the unit is idle.
  task automatic write_forwarding(logic on);
    cfg_bus.valid = 1'b1;
    cfg_bus.data  = on;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  // Pause the snapshot side until every predicted result has come back.
  task automatic drain_results();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_GAP) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic stream_random(int count, bit with_holdoff);
    for (int k = 0; k < count; k++) begin
      if (with_holdoff && k == count / 3) hold_results = 1'b1;
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
        in_bus.valid = 1'b0;
        @(negedge clk_i);
      end
      send_snapshot(random_snapshot());
    end
    in_bus.valid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    hzf_in_t s;

    // Hold every input at a known value through reset.
    rst_ni         = 1'b0;
    quiet          = 1'b1;
    hold_results   = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.payload = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.data   = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, forwarding on as after reset.
    send_snapshot('0);
    send_snapshot('1);  // nopped decode but CSR everywhere: stall wins
    s = shot(USE1_M, 5, 0, 0, WR_M, 5, 0, 0);  // src1 from execute
    s.ex_alu_result = '1;
    s.src1_value    = '0;
    send_snapshot(s);
    send_snapshot(shot(USE2_M | FP2_M, 0, 7, 0, 0, 0, WR_M | WRFP_M | LOAD_M, 7));
    send_snapshot(shot(USE3_M, 0, 0, 9, WR_M, 9, WR_M | WRFP_M, 9));
    send_snapshot(shot(USE1_M, 0, 0, 0, WR_M, 0, WR_M, 0));  // integer x0 never matches
    send_snapshot(shot(USE1_M | FP1_M, 0, 0, 0, WR_M | WRFP_M, 0, 0, 0));  // fp f0 does
    send_snapshot(shot(USE1_M | USE2_M, 3, 4, 0, WR_M | LOAD_M, 4, 0, 0));  // load-use stall
    send_snapshot(shot(USE1_M | USE2_M | USE3_M, 6, 6, 6, WR_M, 6, WR_M, 6));
    send_snapshot(shot(USE2_M, 1, 12, 0, 0, 0, WR_M, 12));  // memory-stage src2 match
    send_snapshot(shot(USE1_M, 2, 0, 0, 0, 0, NOP_M | CSR_M, 0));  // CSR ignores nop bit
    send_snapshot(shot(ID_NOP_M | USE1_M | USE3_M, 8, 0, 8, WR_M, 8, WR_M | WRFP_M, 8));
    send_snapshot(shot(USE1_M, 4, 0, 0, WR_M | WRFP_M, 4, 0, 0));  // file mismatch
    send_snapshot(shot(USE1_M, 10, 0, 0, NOP_M | WR_M, 10, 0, 0));  // nopped writer
    send_snapshot(shot(USE1_M, 11, 0, 0, LOAD_M, 11, 0, 0));  // stage not writing
    send_snapshot(shot(USE1_M | USE2_M | USE3_M, 13, 14, 31, WR_M | LOAD_M, 20,
                       WR_M | WRFP_M | LOAD_M, 31));
    send_snapshot(shot(USE1_M | USE2_M | USE3_M | FP1_M | FP2_M, 31, 31, 31,
                       WR_M | WRFP_M, 31, 0, 0));
    in_bus.valid = 1'b0;

    // Directed part, forwarding off: every match stalls.
    drain_results();
    write_forwarding(1'b0);
    send_snapshot(shot(USE1_M, 5, 0, 0, WR_M, 5, 0, 0));
    send_snapshot(shot(USE2_M, 0, 12, 0, 0, 0, WR_M, 12));
    send_snapshot(shot(USE1_M, 5, 0, 0, WR_M | LOAD_M, 6, 0, 0));
    send_snapshot(shot(0, 0, 0, 0, CSR_M, 0, 0, 0));
    s = shot(USE1_M, 1, 0, 0, 0, 0, 0, 0);
    s.src1_value = '1;
    send_snapshot(s);
    in_bus.valid = 1'b0;

    // Random traffic with idling; one long hold-off on the result side.
    drain_results();
    write_forwarding(1'b1);
    quiet = 1'b0;
    stream_random(180, 1'b1);

    drain_results();
    write_forwarding(1'b0);
    stream_random(150, 1'b0);

    // Back-to-back stretch with no idling, then idling again.
    drain_results();
    write_forwarding(1'b1);
    quiet = 1'b1;
    stream_random(80, 1'b0);
    quiet = 1'b0;
    stream_random(120, 1'b0);

    // Wait out the last results and give stray ones a chance to show up.
    drain_results();
    repeat (8) @(posedge clk_i);

    if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_pipeline_hazard_forwarding_unit_core: PASS");
    end else begin
      $display("tb_pipeline_hazard_forwarding_unit_core: FAIL");
    end
    $finish;
  end

endmodule

// ----- pipeline_hazard_forwarding_unit_core.f -----
design/hzf_pkg.sv
design/hzf_if.sv
design/hzf_decide.sv
design/pipeline_hazard_forwarding_unit_core.sv
design/hzf_checker.sv
tb/sv/tb_pipeline_hazard_forwarding_unit_core.sv
